[rtl/sbds_pkg.sv]
package sbds_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam int WORD_W        = 32;
  localparam int OP_W          = 2;
  localparam int STATUS_W      = 2;
  localparam int COUNT_W       = 7;
  localparam int IN_W          = 40;
  localparam int OUT_W         = 48;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_ONE = 2'd0,
    OP_PUSH_TWO = 2'd1,
    OP_POP_ONE  = 2'd2,
    OP_POP_TWO  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic load_now;
    logic load_read;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_read;
    logic out_free;
  } dp_status_t;

endpackage

[rtl/shared_buffer_dual_stack.sv]
// channel | dir | tdata fields (lsb first)
// s_axis  | in  | operation[1:0], push_value[33:2], zero[39:34]
// m_axis  | out | pop_value[31:0], status[33:32], count_one[40:34], count_two[47:41]
//
// push or refused op: the result goes into the output register as the item is accepted
// successful pop: the store's registered read port captures the word, then S_READ loads it into the output register
// one item in flight; a new item is taken once the output register is free or being taken
// rst clears both stack depths and the output valid; store contents are not cleared
// a stalled result holds in the output register and blocks further input
module shared_buffer_dual_stack #(
  parameter int DEPTH = sbds_pkg::DEPTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [sbds_pkg::IN_W-1:0]  s_tdata,   // operation, push_value
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [sbds_pkg::OUT_W-1:0] m_tdata    // pop_value, status, count_one, count_two
);

  sbds_pkg::ctl_cmd_t   cmd;
  sbds_pkg::dp_status_t dp_st;

  sbds_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .dp_st    (dp_st),
    .cmd      (cmd)
  );

  sbds_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .dp_st    (dp_st)
  );

endmodule

[rtl/sbds_ctrl.sv]
module sbds_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  sbds_pkg::dp_status_t dp_st,
  output sbds_pkg::ctl_cmd_t  cmd
);

  sbds_pkg::state_t state;
  sbds_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sbds_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_tready      = 1'b0;
    cmd.accept    = 1'b0;
    cmd.load_now  = 1'b0;
    cmd.load_read = 1'b0;
    case (state)
      sbds_pkg::S_IDLE: begin
        s_tready = dp_st.out_free;
        if (s_tvalid && dp_st.out_free) begin
          cmd.accept = 1'b1;
          if (dp_st.need_read) begin
            state_next = sbds_pkg::S_READ;
          end else begin
            cmd.load_now = 1'b1;
          end
        end
      end
      sbds_pkg::S_READ: begin
        // output slot is empty here: it was free when the pop was taken
        cmd.load_read = 1'b1;
        state_next    = sbds_pkg::S_IDLE;
      end
      default: begin
        state_next = sbds_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[rtl/sbds_datapath.sv]
module sbds_datapath #(
  parameter int DEPTH = sbds_pkg::DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [sbds_pkg::IN_W-1:0]     s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [sbds_pkg::OUT_W-1:0]    m_tdata,
  input  sbds_pkg::ctl_cmd_t            cmd,
  output sbds_pkg::dp_status_t          dp_st
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);

  logic [sbds_pkg::WORD_W-1:0] mem [DEPTH];
  logic [sbds_pkg::WORD_W-1:0] rdata;

  logic [CW-1:0] depth_one;
  logic [CW-1:0] depth_two;
  logic [CW-1:0] depth_one_next;
  logic [CW-1:0] depth_two_next;
  logic [CW:0]   total;
  logic          full;

  sbds_pkg::op_t               op;
  logic [sbds_pkg::WORD_W-1:0] push_value;
  sbds_pkg::status_t           st;
  logic                        wr_en;
  logic                        rd_en;
  logic [AW-1:0]               addr;

  logic                               out_valid;
  logic [sbds_pkg::WORD_W-1:0]        o_pop;
  sbds_pkg::status_t                  o_status;
  logic [sbds_pkg::COUNT_W-1:0]       o_c1;
  logic [sbds_pkg::COUNT_W-1:0]       o_c2;

  assign op         = sbds_pkg::op_t'(s_tdata[sbds_pkg::OP_W-1:0]);
  assign push_value = s_tdata[sbds_pkg::OP_W +: sbds_pkg::WORD_W];
  assign total      = {1'b0, depth_one} + {1'b0, depth_two};
  assign full       = total >= (CW+1)'(DEPTH);

  always_comb begin
    st             = sbds_pkg::ST_DONE;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    addr           = '0;
    depth_one_next = depth_one;
    depth_two_next = depth_two;
    case (op)
      sbds_pkg::OP_PUSH_ONE: begin
        if (full) begin
          st = sbds_pkg::ST_FULL;
        end else begin
          wr_en          = 1'b1;
          addr           = depth_one[AW-1:0];
          depth_one_next = depth_one + 1'b1;
        end
      end
      sbds_pkg::OP_PUSH_TWO: begin
        if (full) begin
          st = sbds_pkg::ST_FULL;
        end else begin
          wr_en          = 1'b1;
          addr           = AW'(DEPTH - 1) - depth_two[AW-1:0];
          depth_two_next = depth_two + 1'b1;
        end
      end
      sbds_pkg::OP_POP_ONE: begin
        if (depth_one == '0) begin
          st = sbds_pkg::ST_EMPTY;
        end else begin
          rd_en          = 1'b1;
          depth_one_next = depth_one - 1'b1;
          addr           = depth_one_next[AW-1:0];
        end
      end
      sbds_pkg::OP_POP_TWO: begin
        if (depth_two == '0) begin
          st = sbds_pkg::ST_EMPTY;
        end else begin
          rd_en          = 1'b1;
          depth_two_next = depth_two - 1'b1;
          // entry DEPTH-1-depth_two_next, i.e. DEPTH-depth_two
          addr           = AW'(CW'(DEPTH) - depth_two);
        end
      end
      default: begin
        st = sbds_pkg::ST_EMPTY;
      end
    endcase
  end

  assign dp_st.need_read = rd_en;
  assign dp_st.out_free  = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (cmd.accept && wr_en) begin
      mem[addr] <= push_value;
    end
    if (cmd.accept && rd_en) begin
      rdata <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_one <= '0;
      depth_two <= '0;
    end else if (cmd.accept) begin
      depth_one <= depth_one_next;
      depth_two <= depth_two_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_now || cmd.load_read) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_now) begin
      o_pop    <= '0;
      o_status <= st;
      o_c1     <= sbds_pkg::COUNT_W'(depth_one_next);
      o_c2     <= sbds_pkg::COUNT_W'(depth_two_next);
    end else if (cmd.load_read) begin
      // depths already hold the post-pop values
      o_pop    <= rdata;
      o_status <= sbds_pkg::ST_DONE;
      o_c1     <= sbds_pkg::COUNT_W'(depth_one);
      o_c2     <= sbds_pkg::COUNT_W'(depth_two);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {o_c2, o_c1, o_status, o_pop};

endmodule

[rtl/sbds_checker.sv]
module sbds_checker #(
  parameter int DEPTH = sbds_pkg::DEPTH_DEFAULT
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [sbds_pkg::OUT_W-1:0] m_tdata
);

  logic [7:0] count_sum;
  assign count_sum = {1'b0, m_tdata[40:34]} + {1'b0, m_tdata[47:41]};

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[33:32] <= sbds_pkg::ST_EMPTY)
    else $error("illegal status code");

  a_zero_pop: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[33:32] != sbds_pkg::ST_DONE |-> m_tdata[31:0] == 32'd0)
    else $error("nonzero pop value on a failed op");

  a_capacity: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (DEPTH > 127) || (count_sum <= 8'(DEPTH)))
    else $error("stacks hold more than the store");

  // no output shown right after reset
  a_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind shared_buffer_dual_stack sbds_checker #(
  .DEPTH (DEPTH)
) u_sbds_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;

  localparam int STORE_DEPTH = sbds_pkg::DEPTH_DEFAULT;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 10;
  localparam int PRINT_CAP   = 20;

  typedef struct {
    sbds_pkg::op_t op;
    logic [31:0]   word;
  } stack_req_t;

  typedef struct {
    logic [31:0]       pop_value;
    sbds_pkg::status_t status;
    logic [6:0]        count_one;
    logic [6:0]        count_two;
  } stack_res_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [sbds_pkg::IN_W-1:0]  s_tdata = '0;
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [sbds_pkg::OUT_W-1:0] m_tdata;

  shared_buffer_dual_stack #(
    .DEPTH(STORE_DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the two stacks
  logic [31:0] shadow_store [STORE_DEPTH];
  int unsigned height_one = 0;
  int unsigned height_two = 0;

  stack_req_t op_queue[$];
  stack_res_t stack_results[$];

  int unsigned queued_count = 0;
  int unsigned sent_count   = 0;
  int unsigned seen_count   = 0;
  int unsigned full_hits    = 0;
  int unsigned empty_hits   = 0;
  int unsigned pop_hits     = 0;
  int unsigned errors       = 0;
  int unsigned cycles       = 0;
  bit          idle_on      = 1'b1;

  function automatic void apply_stack_op(stack_req_t req);
    stack_res_t res;
    res.pop_value = '0;
    res.status    = sbds_pkg::ST_DONE;
    case (req.op)
      sbds_pkg::OP_PUSH_ONE, sbds_pkg::OP_PUSH_TWO: begin
        if (height_one + height_two >= STORE_DEPTH) begin
          res.status = sbds_pkg::ST_FULL;
          full_hits++;
        end else if (req.op == sbds_pkg::OP_PUSH_ONE) begin
          shadow_store[height_one] = req.word;
          height_one++;
        end else begin
          shadow_store[STORE_DEPTH - 1 - height_two] = req.word;
          height_two++;
        end
      end
      sbds_pkg::OP_POP_ONE: begin
        if (height_one == 0) begin
          res.status = sbds_pkg::ST_EMPTY;
          empty_hits++;
        end else begin
          height_one--;
          res.pop_value = shadow_store[height_one];
          pop_hits++;
        end
      end
      default: begin
        if (height_two == 0) begin
          res.status = sbds_pkg::ST_EMPTY;
          empty_hits++;
        end else begin
          height_two--;
          res.pop_value = shadow_store[STORE_DEPTH - 1 - height_two];
          pop_hits++;
        end
      end
    endcase
    res.count_one = 7'(height_one);
    res.count_two = 7'(height_two);
    stack_results.push_back(res);
  endfunction

  task automatic report_diff(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (errors < PRINT_CAP)
      $display("%0t: result %0d %s got %h want %h", $time, seen_count, what, got, want);
    errors++;
  endtask

  // driver
  stack_req_t cur_req;
  int         send_gap = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        apply_stack_op(cur_req);
        sent_count++;
      end
      if (!(s_tvalid && !s_tready)) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (op_queue.size() > 0 && idle_on && $urandom_range(15) == 0) begin
          send_gap = $urandom_range(9);
          s_tvalid <= 1'b0;
        end else if (op_queue.size() > 0) begin
          cur_req = op_queue.pop_front();
          s_tdata  <= {6'b0, cur_req.word, cur_req.op};
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int recv_gap = 0;
  stack_res_t want_res;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (stack_results.size() == 0) begin
          report_diff("unexpected item", m_tdata[31:0], '0);
        end else begin
          want_res = stack_results.pop_front();
          if (m_tdata[31:0] !== want_res.pop_value)
            report_diff("pop_value", m_tdata[31:0], want_res.pop_value);
          if (m_tdata[33:32] !== want_res.status)
            report_diff("status", 32'(m_tdata[33:32]), 32'(want_res.status));
          if (m_tdata[40:34] !== want_res.count_one)
            report_diff("count_one", 32'(m_tdata[40:34]), 32'(want_res.count_one));
          if (m_tdata[47:41] !== want_res.count_two)
            report_diff("count_two", 32'(m_tdata[47:41]), 32'(want_res.count_two));
        end
        seen_count++;
      end
      if (recv_gap > 0 && idle_on) begin
        recv_gap--;
        m_tready <= 1'b0;
      end else if (idle_on && $urandom_range(15) == 0) begin
        recv_gap = $urandom_range(9);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("shared_buffer_dual_stack: mismatch");
      $finish;
    end
  end

  task automatic queue_item(input sbds_pkg::op_t op, input logic [31:0] word);
    stack_req_t req;
    req.op   = op;
    req.word = word;
    op_queue.push_back(req);
    queued_count++;
  endtask

  // push_pct high fills the store toward full, low drains toward empty
  task automatic queue_random(input int n, input int push_pct);
    sbds_pkg::op_t op;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < push_pct)
        op = $urandom_range(1) ? sbds_pkg::OP_PUSH_TWO : sbds_pkg::OP_PUSH_ONE;
      else
        op = $urandom_range(1) ? sbds_pkg::OP_POP_TWO : sbds_pkg::OP_POP_ONE;
      queue_item(op, $urandom());
    end
  endtask

  task automatic queue_sweep(input int total);
    int left;
    int len;
    int pick;
    left = total;
    while (left > 0) begin
      len  = $urandom_range(120, 30);
      pick = $urandom_range(2);
      if (len > left)
        len = left;
      queue_random(len, pick == 0 ? 85 : (pick == 1 ? 15 : 50));
      left -= len;
    end
  endtask

  task automatic drain_queue;
    while (op_queue.size() != 0)
      @(negedge clk);
  endtask

  task automatic wait_all_done;
    while (sent_count != queued_count || stack_results.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty pops, word extremes, lifo order on both stacks
    queue_item(sbds_pkg::OP_POP_ONE, 32'hFFFF_FFFF);
    queue_item(sbds_pkg::OP_POP_TWO, 32'h0000_0000);
    queue_item(sbds_pkg::OP_PUSH_ONE, 32'h7FFF_FFFF);
    queue_item(sbds_pkg::OP_PUSH_ONE, 32'h8000_0000);
    queue_item(sbds_pkg::OP_PUSH_TWO, 32'h0000_0000);
    queue_item(sbds_pkg::OP_PUSH_TWO, 32'hFFFF_FFFF);
    queue_item(sbds_pkg::OP_PUSH_ONE, 32'h0000_0001);
    queue_item(sbds_pkg::OP_PUSH_TWO, 32'hAAAA_5555);
    queue_item(sbds_pkg::OP_POP_ONE, 32'hA5A5_A5A5);
    queue_item(sbds_pkg::OP_POP_ONE, 32'h5A5A_5A5A);
    queue_item(sbds_pkg::OP_POP_TWO, 32'hFFFF_FFFF);
    queue_item(sbds_pkg::OP_POP_ONE, 32'h0000_0000);
    queue_item(sbds_pkg::OP_POP_ONE, 32'h1234_5678);
    queue_item(sbds_pkg::OP_POP_TWO, 32'h8000_0000);
    queue_item(sbds_pkg::OP_POP_TWO, 32'h7FFF_FFFF);
    queue_item(sbds_pkg::OP_POP_TWO, 32'h0000_0000);
    queue_item(sbds_pkg::OP_PUSH_TWO, 32'h5555_AAAA);
    queue_item(sbds_pkg::OP_PUSH_ONE, $urandom());
    queue_item(sbds_pkg::OP_POP_TWO, $urandom());
    queue_item(sbds_pkg::OP_POP_ONE, $urandom());

    // hold off the sender until the block has emptied out
    wait_all_done();

    queue_sweep(600);
    drain_queue();
    idle_on = 1'b0;
    queue_sweep(150);
    drain_queue();
    idle_on = 1'b1;
    queue_sweep(400);
    drain_queue();
    idle_on = 1'b0;
    queue_sweep(250);

    wait_all_done();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (stack_results.size() != 0) begin
      $display("%0d results never arrived", stack_results.size());
      errors++;
    end
    $display("ran %0d stack ops, %0d results checked in %0d cycles",
             sent_count, seen_count, cycles);
    $display("successful pops %0d, refused pushes on full %0d, pops on empty %0d",
             pop_hits, full_hits, empty_hits);
    if (errors == 0) begin
      $display("shared_buffer_dual_stack: match");
    end else begin
      $display("shared_buffer_dual_stack: mismatch");
    end
    $finish;
  end

endmodule
